// ----- rtl/hga_pkg.sv -----
// Shared constants, codes and control types of the generational handle allocator.
package hga_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int IDX_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int VER_W     = 16;
	localparam int FIELD_W   = 16;
	localparam int HANDLE_W  = 32;
	localparam int CMD_W     = 2;
	localparam int ERR_W     = 2;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
	localparam logic [VER_W-1:0] FIRST_VER = VER_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_SPAWN   = 2'd0,
		CMD_LOOKUP  = 2'd1,
		CMD_RECYCLE = 2'd2,
		CMD_COUNT   = 2'd3
	} command_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK     = 2'd0,
		ERR_FULL   = 2'd1,
		ERR_UNUSED = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic pop_read;
		logic commit_exec;
		logic commit_pop;
	} ctrl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic pop_needed;
	} status_t;

endpackage

// ----- rtl/hga_req_if.sv -----
// Request channel of the handle allocator: command and handle.
interface hga_req_if;
	logic                          valid;
	logic                          ready;
	logic [hga_pkg::CMD_W-1:0]     command;
	logic [hga_pkg::HANDLE_W-1:0]  handle_in;

	modport source (output valid, output command, output handle_in, input ready);
	modport sink (input valid, input command, input handle_in, output ready);
endinterface

// ----- rtl/hga_rsp_if.sv -----
// Response channel of the handle allocator: handle, found flag, live count, error.
interface hga_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [hga_pkg::HANDLE_W-1:0]  handle_out;
	logic                          found;
	logic [hga_pkg::CNT_W-1:0]     live_count;
	logic [hga_pkg::ERR_W-1:0]     error_code;

	modport source (output valid, output handle_out, output found, output live_count,
		output error_code, input ready);
	modport sink (input valid, input handle_out, input found, input live_count,
		input error_code, output ready);
endinterface

// ----- rtl/hga_controller.sv -----
// Sequencing state machine of the handle allocator and the response valid flag.
module hga_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	input  hga_pkg::status_t   status,
	output hga_pkg::ctrl_t     ctrl
);

	hga_pkg::state_t state_q;
	hga_pkg::state_t state_nxt;
	logic            rsp_valid_q;
	logic            out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hga_pkg::S_IDLE: begin
				if (req_valid) begin
					state_nxt = hga_pkg::S_EXEC;
				end
			end
			hga_pkg::S_EXEC: begin
				if (status.pop_needed) begin
					state_nxt = hga_pkg::S_POP;
				end else if (out_free) begin
					state_nxt = hga_pkg::S_IDLE;
				end
			end
			hga_pkg::S_POP: begin
				if (out_free) begin
					state_nxt = hga_pkg::S_IDLE;
				end
			end
			default: state_nxt = hga_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req_ready = 1'b0;
		ctrl      = '0;
		case (state_q)
			hga_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				ctrl.accept = req_valid;
			end
			hga_pkg::S_EXEC: begin
				if (status.pop_needed) begin
					ctrl.pop_read = 1'b1;
				end else begin
					ctrl.commit_exec = out_free;
				end
			end
			hga_pkg::S_POP: begin
				ctrl.commit_pop = out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// Hold state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hga_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.commit_exec || ctrl.commit_pop) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/hga_datapath.sv -----
// Version memory, free stack, counters and response register of the handle allocator.
module hga_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hga_pkg::ctrl_t                ctrl,
	output hga_pkg::status_t              status,
	input  logic [hga_pkg::CMD_W-1:0]     command,
	input  logic [hga_pkg::HANDLE_W-1:0]  handle_in,
	output logic [hga_pkg::HANDLE_W-1:0]  handle_out,
	output logic                          found,
	output logic [hga_pkg::CNT_W-1:0]     live_count,
	output logic [hga_pkg::ERR_W-1:0]     error_code
);

	// Storage
	logic [hga_pkg::VER_W-1:0] ver_mem [hga_pkg::MAX_SLOTS];
	logic [hga_pkg::IDX_W-1:0] stk_mem [hga_pkg::MAX_SLOTS];

	hga_pkg::command_t          cmd_q;
	logic [hga_pkg::HANDLE_W-1:0] handle_q;
	logic [hga_pkg::VER_W-1:0]  ver_rd_q;
	logic [hga_pkg::IDX_W-1:0]  stk_rd_q;
	logic [hga_pkg::CNT_W-1:0]  depth_q;
	logic [hga_pkg::CNT_W-1:0]  used_q;

	logic [hga_pkg::HANDLE_W-1:0] handle_out_q;
	logic                         found_q;
	logic [hga_pkg::CNT_W-1:0]    live_q;
	hga_pkg::err_t                err_q;

	logic [hga_pkg::FIELD_W-1:0] req_idx;
	logic [hga_pkg::VER_W-1:0]   req_ver;
	logic                        in_use;
	logic [hga_pkg::CNT_W-1:0]   depth_m1;
	logic [hga_pkg::IDX_W-1:0]   ver_ra;

	logic [hga_pkg::CNT_W-1:0]    depth_nxt;
	logic [hga_pkg::CNT_W-1:0]    used_nxt;
	logic                         ver_we;
	logic [hga_pkg::IDX_W-1:0]    ver_wa;
	logic [hga_pkg::VER_W-1:0]    ver_wd;
	logic                         stk_we;
	logic [hga_pkg::HANDLE_W-1:0] res_handle;
	logic                         res_found;
	hga_pkg::err_t                res_err;
	logic                         commit;

	assign req_idx  = handle_q[hga_pkg::FIELD_W-1:0];
	assign req_ver  = handle_q[hga_pkg::HANDLE_W-1:hga_pkg::FIELD_W];
	assign in_use   = 32'(req_idx) < 32'(used_q);
	assign depth_m1 = depth_q - hga_pkg::ONE_CNT;
	assign ver_ra   = ctrl.pop_read ? stk_rd_q : handle_in[hga_pkg::IDX_W-1:0];
	assign commit   = ctrl.commit_exec || ctrl.commit_pop;

	assign status.pop_needed = (cmd_q == hga_pkg::CMD_SPAWN) && (depth_q != '0);

	// Work out the state update and result of the current request
	always_comb begin
		depth_nxt  = depth_q;
		used_nxt   = used_q;
		ver_we     = 1'b0;
		ver_wa     = req_idx[hga_pkg::IDX_W-1:0];
		ver_wd     = ver_rd_q + hga_pkg::FIRST_VER;
		stk_we     = 1'b0;
		res_handle = '0;
		res_found  = 1'b0;
		res_err    = hga_pkg::ERR_OK;
		if (ctrl.commit_pop) begin
			depth_nxt  = depth_m1;
			res_handle = {ver_rd_q, hga_pkg::FIELD_W'(stk_rd_q)};
		end else if (ctrl.commit_exec) begin
			case (cmd_q)
				hga_pkg::CMD_SPAWN: begin
					// Free stack is empty here: take a fresh slot
					if (used_q < hga_pkg::MAX_CNT) begin
						ver_we     = 1'b1;
						ver_wa     = used_q[hga_pkg::IDX_W-1:0];
						ver_wd     = hga_pkg::FIRST_VER;
						used_nxt   = used_q + hga_pkg::ONE_CNT;
						res_handle = {hga_pkg::FIRST_VER, hga_pkg::FIELD_W'(used_q)};
					end else begin
						res_err = hga_pkg::ERR_FULL;
					end
				end
				hga_pkg::CMD_LOOKUP: begin
					res_found = in_use && (ver_rd_q == req_ver);
				end
				hga_pkg::CMD_RECYCLE: begin
					// Drop a push that would overfill the stack
					if (!in_use) begin
						res_err = hga_pkg::ERR_UNUSED;
					end else if (depth_q < used_q) begin
						ver_we    = 1'b1;
						stk_we    = 1'b1;
						depth_nxt = depth_q + hga_pkg::ONE_CNT;
					end
				end
				default: begin
					res_err = hga_pkg::ERR_OK;
				end
			endcase
		end
	end

	// Capture request and read both memories
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q    <= hga_pkg::command_t'(command);
			handle_q <= handle_in;
			stk_rd_q <= stk_mem[depth_m1[hga_pkg::IDX_W-1:0]];
		end
		if (ctrl.accept || ctrl.pop_read) begin
			ver_rd_q <= ver_mem[ver_ra];
		end
		if (ver_we) begin
			ver_mem[ver_wa] <= ver_wd;
		end
		if (stk_we) begin
			stk_mem[depth_q[hga_pkg::IDX_W-1:0]] <= req_idx[hga_pkg::IDX_W-1:0];
		end
	end

	// Advance counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			used_q  <= '0;
		end else if (commit) begin
			depth_q <= depth_nxt;
			used_q  <= used_nxt;
		end
	end

	// Hold the response until the next commit
	always_ff @(posedge clk) begin
		if (commit) begin
			handle_out_q <= res_handle;
			found_q      <= res_found;
			live_q       <= used_nxt - depth_nxt;
			err_q        <= res_err;
		end
	end

	assign handle_out = handle_out_q;
	assign found      = found_q;
	assign live_count = live_q;
	assign error_code = err_q;

endmodule

// ----- rtl/generational_handle_allocator_unit.sv -----
// Top level of the generational handle allocator.
// IDLE takes a request, registering it and reading both memories. EXEC registers the
// response; a spawn that reuses a freed slot first reads the version memory at the popped
// index (free stack read, then version memory read) and POP registers the response.
// Registering waits while an earlier response is held; a new request is taken only after.
// Reset: counters, state and the response valid flag clear at once; memories are not cleared.
module generational_handle_allocator_unit (
	input  logic       clk,
	input  logic       arst_n,
	hga_req_if.sink    req,
	hga_rsp_if.source  rsp
);

	hga_pkg::ctrl_t   ctrl;
	hga_pkg::status_t status;

	hga_controller u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.status    (status),
		.ctrl      (ctrl)
	);

	hga_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.status     (status),
		.command    (req.command),
		.handle_in  (req.handle_in),
		.handle_out (rsp.handle_out),
		.found      (rsp.found),
		.live_count (rsp.live_count),
		.error_code (rsp.error_code)
	);

	// Block takes one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while previous one in flight");

	// Live count never exceeds the slot table
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.live_count <= hga_pkg::MAX_CNT)
		else $error("live count beyond slot table");

	// A lookup hit carries no handle and no error
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.handle_out == '0 && rsp.error_code == hga_pkg::ERR_OK)
		else $error("found flag with handle or error");

	// A failed request returns no handle
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error_code != hga_pkg::ERR_OK |-> rsp.handle_out == '0)
		else $error("handle returned with error");

endmodule
